/* rtl/blids_pkg.sv */
// ----------------------------------------------------------------------------
// blids_pkg
// Shared types, codes and helpers for the bounded list core and its cells.
// ----------------------------------------------------------------------------
package blids_pkg;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_DELETE = 3'd1;
    localparam logic [2:0] FN_INSERT = 3'd2;
    localparam logic [2:0] FN_READ   = 3'd3;
    localparam logic [2:0] FN_FIRST  = 3'd4;
    localparam logic [2:0] FN_LAST   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] MW_8  = 2'd0;
    localparam logic [1:0] MW_16 = 2'd1;
    localparam logic [1:0] MW_32 = 2'd2;

    // low 32 bits hold -404, upper half zero
    localparam logic [63:0] BAD_READ_WORD = 64'h0000_0000_FFFF_FE6C;

    typedef logic [63:0] word_t;

    // Command broadcast to every cell on an accepted beat
    typedef struct packed {
        logic       en;
        logic       ins;
        logic       del;
        logic [7:0] pos;
        word_t      key;
        logic [1:0] msel;
    } cell_cmd_t;

    function automatic word_t width_mask(input logic [1:0] msel);
        word_t m;
        case (msel)
            MW_8:    m = 64'h0000_0000_0000_00FF;
            MW_16:   m = 64'h0000_0000_0000_FFFF;
            MW_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

/* rtl/blids_cell.sv */
// ----------------------------------------------------------------------------
// blids_cell
// One list slot: holds a word, shifts with its neighbours and flags a match.
// ----------------------------------------------------------------------------
module blids_cell
    import blids_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic [8:0] count,
    input  word_t     prev_word,
    input  word_t     next_word,
    output word_t     word,
    output logic      hit
);

    localparam logic [7:0] Idx = 8'(IDX);

    word_t word_reg;
    word_t word_next;
    logic  hit_reg;
    logic  hit_next;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.ins)
        begin
            if (Idx == cmd.pos)
                word_next = cmd.key;
            else if (Idx > cmd.pos)
                word_next = prev_word;
        end
        else if (cmd.del && (Idx >= cmd.pos))
        begin
            word_next = next_word;
        end
        // compare against contents before this beat's shift
        hit_next = (((word_reg ^ cmd.key) & width_mask(cmd.msel)) == '0)
                   && ({1'b0, Idx} < count);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            word_reg <= word_next;
            hit_reg  <= hit_next;
        end
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

/* rtl/bounded_list_insert_delete_search_core.sv */
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_search_core
// Ordered list of 64-bit words held in a row of shifting cells, with append,
// insert, delete, read and first/last masked search.
// The cell row updates and registers its compares on the accept edge; once
// the output side is free, the matches are encoded, the read data selected
// and the result registered. in_stall holds off a new beat until then.
// Reset: asynchronous, clears the element count and the handshake state; the
// cell contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_search_core
    import blids_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  position,
    input  logic [63:0] value,
    input  logic [1:0]  match_width,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [7:0]  found_position,
    output logic [63:0] data,
    output logic [8:0]  count,
    output logic        empty_res
);

    localparam logic [8:0] Cap = 9'(CAPACITY);

    word_t                 words [CAPACITY];
    logic [CAPACITY-1:0]   hits;
    cell_cmd_t             cmd;

    logic [8:0]  count_reg;
    logic [8:0]  count_next;
    logic        s1_valid_reg;
    logic [2:0]  s1_func_reg;
    logic [1:0]  s1_status_reg;
    logic [1:0]  status_next;
    logic [7:0]  s1_pos_reg;
    logic        s1_bad_reg;
    logic        bad_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        found_reg;
    logic [7:0]  fpos_reg;
    word_t       data_reg;
    logic [8:0]  count_out_reg;

    logic        accept;
    logic        s1_done;
    logic        in_range;
    logic        is_full;
    logic        found_next;
    logic [7:0]  fpos_next;
    word_t       data_next;

    assign in_stall = s1_valid_reg;
    assign accept   = in_valid && !s1_valid_reg;
    assign s1_done  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_range = {1'b0, position} < count_reg;
    assign is_full  = count_reg >= Cap;

    // Decode the beat into a cell command and the new count
    always_comb
    begin
        cmd.en      = accept;
        cmd.ins     = 1'b0;
        cmd.del     = 1'b0;
        cmd.pos     = position;
        cmd.key     = value;
        cmd.msel    = match_width;
        count_next  = count_reg;
        status_next = ST_OK;
        bad_next    = 1'b0;
        case (func)
            FN_APPEND, FN_INSERT:
            begin
                if (func == FN_APPEND || !in_range)
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = accept;
                        cmd.pos    = count_reg[7:0];
                        count_next = count_reg + 9'd1;
                    end
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + 9'd1;
                end
            end
            FN_DELETE:
            begin
                if (in_range)
                begin
                    cmd.del    = accept;
                    count_next = count_reg - 9'd1;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            FN_READ:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                    bad_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        blids_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .count     (count_reg),
            .prev_word ((i == 0) ? value : words[(i == 0) ? 0 : i - 1]),
            .next_word ((i == CAPACITY - 1) ? words[i]
                                            : words[(i == CAPACITY - 1) ? i : i + 1]),
            .word      (words[i]),
            .hit       (hits[i])
        );
    end

    // Encode matches and pick the read word from the registered row
    always_comb
    begin
        found_next = 1'b0;
        fpos_next  = '0;
        data_next  = '0;
        if (s1_func_reg == FN_FIRST)
        begin
            for (int i = CAPACITY - 1; i >= 0; i--)
            begin
                if (hits[i])
                begin
                    found_next = 1'b1;
                    fpos_next  = 8'(i);
                end
            end
        end
        else if (s1_func_reg == FN_LAST)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (hits[i])
                begin
                    found_next = 1'b1;
                    fpos_next  = 8'(i);
                end
            end
        end
        else if (s1_func_reg == FN_READ)
        begin
            if (s1_bad_reg)
            begin
                data_next = BAD_READ_WORD;
            end
            else
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (s1_pos_reg == 8'(i))
                        data_next = data_next | words[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg    <= count_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= func;
            s1_status_reg <= status_next;
            s1_pos_reg    <= position;
            s1_bad_reg    <= bad_next;
        end
        // hold the result beat while the far side stalls
        if (s1_done)
        begin
            status_reg    <= s1_status_reg;
            found_reg     <= found_next;
            fpos_reg      <= fpos_next;
            data_reg      <= data_next;
            count_out_reg <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign data           = data_reg;
    assign count          = count_out_reg;
    assign empty_res      = (count_out_reg == 9'd0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Cap)
        else $error("element count beyond capacity");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (count == Cap))
        else $error("full status with room left");

    a_found_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (!empty_res && {1'b0, found_position} < count))
        else $error("match reported outside the list");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && $past(count_next) == count_reg))
        else $error("second beat taken while one is in flight");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the bounded list core against a shadow list that is kept in step
// with every accepted command. Commands are queued up front (a directed
// opening, then weighted random traffic), driven on the falling edge and
// scored beat by beat on the rising edge, with random idle gaps at the input and random stalls at the output.
// ----------------------------------------------------------------------------
module testbench
    import blids_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = 16;
    localparam int          RANDOM_CMDS  = 1450;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          IDLE_PCT     = 37;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_AT     = 1000;
    localparam int          QUIET_FROM   = 600;
    localparam int          QUIET_TO     = 800;
    localparam logic [2:0]  FN_NOP6      = 3'd6;
    localparam logic [2:0]  FN_NOP7      = 3'd7;
    localparam logic [1:0]  MW_64        = 2'd3;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  position;
        logic [63:0] value;
        logic [1:0]  match_width;
    } list_cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [7:0]  found_position;
        logic [63:0] data;
        logic [8:0]  count;
        logic        empty_res;
    } list_reply_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [7:0]  position;
    logic [63:0] value;
    logic [1:0]  match_width;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        found;
    logic [7:0]  found_position;
    logic [63:0] data;
    logic [8:0]  count;
    logic        empty_res;

    list_cmd_t   cmd_backlog[$];
    list_reply_t reply_due[$];
    logic [63:0] shadow_words[LIST_DEPTH];
    int          shadow_len;
    logic [63:0] word_pool[4];

    int          cycle_count;
    int          fault_count;
    int          cmds_accepted;
    int          replies_seen;
    int          hold_left;
    bit          hold_done;
    bit          drain_done;
    bit          beat_taken;

    bounded_list_insert_delete_search_core #(.CAPACITY(LIST_DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .position       (position),
        .value          (value),
        .match_width    (match_width),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found          (found),
        .found_position (found_position),
        .data           (data),
        .count          (count),
        .empty_res      (empty_res)
    );

    always #6 clk = ~clk;

    function automatic logic [1:0] push_tail(input logic [63:0] w);
        if (shadow_len >= LIST_DEPTH)
            return ST_FULL;
        shadow_words[shadow_len] = w;
        shadow_len++;
        return ST_OK;
    endfunction

    // Apply one command to the shadow list and return the reply it must give
    function automatic list_reply_t apply_list_cmd(input list_cmd_t c);
        list_reply_t r;
        logic [63:0] mask;
        int          pos;
        int          i;
        r = '{ST_OK, 1'b0, 8'd0, 64'd0, 9'd0, 1'b0};
        pos = c.position;
        mask = (c.match_width == MW_64) ? '1 : ((64'd1 << (8 << c.match_width)) - 64'd1);
        case (c.func)
            FN_APPEND: r.status = push_tail(c.value);
            FN_DELETE:
            begin
                if (pos >= shadow_len) begin
                    r.status = ST_RANGE;
                end
                else begin
                    shadow_len--;
                    for (i = pos; i < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                end
            end
            FN_INSERT:
            begin
                if (pos >= shadow_len) begin
                    r.status = push_tail(c.value);
                end
                else if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end
                else begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = c.value;
                    shadow_len++;
                end
            end
            FN_READ:
            begin
                if (pos >= shadow_len) begin
                    r.status = ST_RANGE;
                    r.data   = BAD_READ_WORD;
                end
                else begin
                    r.data = shadow_words[pos];
                end
            end
            FN_FIRST:
            begin
                for (i = 0; i < shadow_len && !r.found; i++) begin
                    if (((shadow_words[i] ^ c.value) & mask) == 64'd0) begin
                        r.found          = 1'b1;
                        r.found_position = 8'(i);
                    end
                end
            end
            FN_LAST:
            begin
                for (i = shadow_len - 1; i >= 0 && !r.found; i--) begin
                    if (((shadow_words[i] ^ c.value) & mask) == 64'd0) begin
                        r.found          = 1'b1;
                        r.found_position = 8'(i);
                    end
                end
            end
            default: ;
        endcase
        r.count     = 9'(shadow_len);
        r.empty_res = (shadow_len == 0);
        return r;
    endfunction

    task automatic queue_cmd(input logic [2:0] f, input logic [7:0] p,
                             input logic [63:0] v, input logic [1:0] mw);
        list_cmd_t c;
        c.func        = f;
        c.position    = p;
        c.value       = v;
        c.match_width = mw;
        cmd_backlog.push_back(c);
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Mostly words from a small pool, half with the upper bits stirred, so that
    // narrow searches hit often while wide ones still miss
    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        if ($urandom_range(0, 99) < 65) begin
            w = word_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 1))
                w = w ^ ({$urandom, $urandom} << (8 << $urandom_range(0, 2)));
        end
        else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    task automatic queue_random(input int k);
        logic [2:0] f;
        logic [7:0] p;
        int         r;
        bit         grow;
        grow = ((k / 120) % 2) == 0;
        r    = $urandom_range(0, 99);
        if (grow)
            f = (r < 30) ? FN_APPEND : (r < 55) ? FN_INSERT : (r < 67) ? FN_DELETE :
                (r < 80) ? FN_READ : (r < 89) ? FN_FIRST : (r < 98) ? FN_LAST :
                ($urandom_range(0, 1) ? FN_NOP6 : FN_NOP7);
        else
            f = (r < 10) ? FN_APPEND : (r < 20) ? FN_INSERT : (r < 60) ? FN_DELETE :
                (r < 75) ? FN_READ : (r < 86) ? FN_FIRST : (r < 98) ? FN_LAST :
                ($urandom_range(0, 1) ? FN_NOP6 : FN_NOP7);
        if ($urandom_range(0, 99) < 15)
            p = 8'($urandom_range(0, 255));
        else if (f == FN_DELETE && $urandom_range(0, 99) < 70)
            p = 8'($urandom_range(0, 3));
        else
            p = 8'($urandom_range(0, LIST_DEPTH + 1));
        queue_cmd(f, p, pick_word(), 2'($urandom_range(0, 3)));
    endtask

    // Sender side: record accepted beats and predict their replies
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            reply_due.push_back(apply_list_cmd('{func, position, value, match_width}));
            cmds_accepted++;
            beat_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        list_cmd_t c;
        if (rst_n && (!in_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (cmds_accepted >= DRAIN_AT && !drain_done && reply_due.size() != 0) begin
                in_valid <= 1'b0;
            end
            else begin
                if (cmds_accepted >= DRAIN_AT)
                    drain_done = 1'b1;
                if (cmd_backlog.size() != 0 &&
                    ((cmds_accepted >= QUIET_FROM && cmds_accepted < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    c = cmd_backlog.pop_front();
                    func        <= c.func;
                    position    <= c.position;
                    value       <= c.value;
                    match_width <= c.match_width;
                    in_valid    <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: random stalls, one long hold to back the block up
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (replies_seen >= HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (replies_seen >= QUIET_FROM && replies_seen < QUIET_TO) begin
                out_stall <= 1'b0;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        list_reply_t e;
        if (rst_n && out_valid && !out_stall) begin
            replies_seen++;
            if (reply_due.size() == 0) begin
                report_fault($sformatf("reply %0d arrived with nothing outstanding",
                                       replies_seen));
            end
            else begin
                e = reply_due.pop_front();
                if (status !== e.status || found !== e.found ||
                    found_position !== e.found_position || data !== e.data ||
                    count !== e.count || empty_res !== e.empty_res)
                    report_fault({
                        $sformatf("reply %0d: expected st=%0d fnd=%0d pos=%0d ",
                                  replies_seen, e.status, e.found, e.found_position),
                        $sformatf("data=%h cnt=%0d emp=%0d, ",
                                  e.data, e.count, e.empty_res),
                        $sformatf("got st=%0d fnd=%0d pos=%0d data=%h cnt=%0d emp=%0d",
                                  status, found, found_position, data, count,
                                  empty_res)});
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int j;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FN_APPEND;
        position    = 8'd0;
        value       = 64'd0;
        match_width = MW_8;
        out_stall   = 1'b0;
        shadow_len  = 0;
        for (j = 0; j < 4; j++)
            word_pool[j] = {$urandom, $urandom};

        // Empty list: out-of-range read and delete, search miss, spare code
        queue_cmd(FN_READ,   8'd0,   64'd0, MW_8);
        queue_cmd(FN_DELETE, 8'd255, 64'd0, MW_8);
        queue_cmd(FN_LAST,   8'd0,   64'd0, MW_64);
        queue_cmd(FN_NOP7,   8'd255, '1,    MW_64);
        // Fill to capacity through every way in, past-end insert among them
        queue_cmd(FN_APPEND, 8'd0,   64'd0, MW_8);
        queue_cmd(FN_APPEND, 8'd0,   '1,    MW_8);
        queue_cmd(FN_INSERT, 8'd0,   64'h0123_4567_89AB_CDEF, MW_16);
        queue_cmd(FN_INSERT, 8'd255, 64'h8000_0000_0000_0001, MW_32);
        queue_cmd(FN_INSERT, 8'd1,   64'h5A5A_5A5A_5A5A_5A5A, MW_64);
        for (j = 0; j < 11; j++)
            queue_cmd((j % 2) ? FN_INSERT : FN_APPEND, 8'(j + 2),
                      64'h0000_0000_0000_CDEF + (64'(j) << 32), 2'(j % 4));
        // Full list: dropped words, reads and searches at every width, then a spare code, deletes and a read
        queue_cmd(FN_APPEND, 8'd0,   64'h0000_0000_0000_DEAD, MW_8);
        queue_cmd(FN_INSERT, 8'd3,   64'h0000_0000_0000_BEEF, MW_8);
        queue_cmd(FN_INSERT, 8'd16,  64'h0000_0000_0000_F00D, MW_8);
        queue_cmd(FN_READ,   8'd255, 64'd0, MW_8);
        queue_cmd(FN_READ,   8'd15,  64'd0, MW_8);
        queue_cmd(FN_FIRST,  8'd0,   64'hFFFF_FFFF_FFFF_CDEF, MW_16);
        queue_cmd(FN_LAST,   8'd0,   64'h0000_0000_0000_00EF, MW_8);
        queue_cmd(FN_LAST,   8'd0,   64'h0000_0003_0000_CDEF, MW_32);
        queue_cmd(FN_FIRST,  8'd0,   '1,    MW_64);
        queue_cmd(FN_FIRST,  8'd0,   64'd1, MW_64);
        queue_cmd(FN_NOP6,   8'd0,   64'd0, MW_8);
        queue_cmd(FN_DELETE, 8'd255, 64'd0, MW_8);
        queue_cmd(FN_DELETE, 8'd0,   64'd0, MW_8);
        queue_cmd(FN_READ,   8'd0,   64'd0, MW_8);
        for (j = 0; j < RANDOM_CMDS; j++)
            queue_random(j);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (reply_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/blids_pkg.sv
rtl/blids_cell.sv
rtl/bounded_list_insert_delete_search_core.sv
verif/testbench.sv
